>>> sv/ppd_pkg.sv
// Shared types and constants for the projective point to DAC mapper.
// Holds register indexes, status codes, sequencer states and control structs.
// No dependencies.
`default_nettype none

package ppd_pkg;

	localparam int COORD_W        = 16;
	localparam int CFG_IDX_W      = 4;
	localparam int DAC_BITS_DEF   = 12;
	localparam int COORD_FRAC_DEF = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X  = 4'd0,
		REG_SHEAR_Y  = 4'd1,
		REG_PERSP_X  = 4'd2,
		REG_SHEAR_X  = 4'd3,
		REG_SCALE_Y  = 4'd4,
		REG_PERSP_Y  = 4'd5,
		REG_OFFSET_X = 4'd6,
		REG_OFFSET_Y = 4'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_ZERO  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ACC_DEN,
		ACC_NUM_X,
		ACC_NUM_Y
	} acc_sel_t;

	// one product term per multiplier pass, in issue order
	typedef enum logic [2:0] {
		T_DEN_X,
		T_DEN_Y,
		T_NUM_XX,
		T_NUM_XY,
		T_NUM_YX,
		T_NUM_YY
	} mac_term_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_RUN
	} div_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DRAIN,
		S_CHKW,
		S_DIVX,
		S_DIVY,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic     init;
		logic     mul;
		acc_sel_t dst;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic oor;
	} div_stat_t;

	// accumulator width: two 16x16 products plus the 2^(2*frac) unit term, signed
	function automatic int acc_width(input int frac);
		return ((2 * frac > 32) ? 2 * frac : 32) + 3;
	endfunction

endpackage

`default_nettype wire

>>> sv/projective_point_to_dac.sv
// Top level of the projective point to DAC mapper: registers, point store,
// sequencer. Uses ppd_pkg, ppd_mac and ppd_div.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word: mode, coord_x, coord_y,
//   signed Q3.12. Mode 1 adds the word to the stored last point, saturating.
//   Output channel (out_valid/out_ready) returns one word per input: dac_x,
//   dac_y and status (ok, outside DAC range, zero denominator).
//   Configuration: cfg_we writes cfg_wdata to register cfg_idx;
//   indexes beyond seven are dropped. Write only while the block is idle.
// Timing:
//   One item occupies the block from acceptance until in_ready rises again, and its
//   result word shows up on that same cycle; a zero denominator skips both
//   divides and finishes early.
//   Six passes through the one shared multiplier build the denominator and
//   both numerators, then one serial divider produces a code bit per cycle,
//   first for x, then for y.
//   in_ready is high only while the sequencer is idle.
// Reset:
//   arst_n clears the matrix to identity, the last point to zero and both
//   channels to empty. A stalled receiver holds the result in the output
//   register; the next word is still accepted, and finishes once it drains.
`default_nettype none

module projective_point_to_dac import ppd_pkg::*; #(
	parameter int DAC_BITS   = DAC_BITS_DEF,
	parameter int COORD_FRAC = COORD_FRAC_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      mode,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [DAC_BITS-1:0]            dac_x,
	output logic [DAC_BITS-1:0]            dac_y,
	output logic [1:0]                     status,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [COORD_W-1:0]        cfg_wdata
);

	localparam int ACC_W = acc_width(COORD_FRAC);

	// configuration registers, Q3.12 style signed
	logic signed [COORD_W-1:0] scale_x_q;
	logic signed [COORD_W-1:0] shear_y_q;
	logic signed [COORD_W-1:0] persp_x_q;
	logic signed [COORD_W-1:0] shear_x_q;
	logic signed [COORD_W-1:0] scale_y_q;
	logic signed [COORD_W-1:0] persp_y_q;
	logic signed [COORD_W-1:0] offset_x_q;
	logic signed [COORD_W-1:0] offset_y_q;

	// stored last point, also the operand point of the item in flight
	logic signed [COORD_W-1:0] last_x_q;
	logic signed [COORD_W-1:0] last_y_q;
	logic signed [COORD_W-1:0] pt_x;
	logic signed [COORD_W-1:0] pt_y;

	seq_state_t                state_q;
	seq_state_t                state_d;
	mac_term_t                 step_q;
	logic                      zero_q;
	logic [DAC_BITS-1:0]       code_x_q;
	logic                      oor_x_q;
	logic                      out_valid_q;
	logic [DAC_BITS-1:0]       dac_x_q;
	logic [DAC_BITS-1:0]       dac_y_q;
	status_t                   status_q;

	mac_ctl_t                  mac_ctl;
	logic signed [COORD_W-1:0] op_a;
	logic signed [COORD_W-1:0] op_b;
	logic signed [ACC_W-1:0]   init_den;
	logic signed [ACC_W-1:0]   init_num_x;
	logic signed [ACC_W-1:0]   init_num_y;
	logic signed [ACC_W-1:0]   den;
	logic signed [ACC_W-1:0]   num_x;
	logic signed [ACC_W-1:0]   num_y;

	logic                      div_start;
	logic signed [ACC_W-1:0]   div_num;
	logic [DAC_BITS-1:0]       div_code;
	div_stat_t                 div_stat;

	logic                      accept;
	logic                      out_load;
	status_t                   res_status;

	function automatic logic signed [COORD_W-1:0] sat_add(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] s;
		s = (COORD_W + 1)'(a) + (COORD_W + 1)'(b);
		if (s[COORD_W] != s[COORD_W-1]) begin
			return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
		return s[COORD_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Configuration write port
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q  <= COORD_W'(1) << COORD_FRAC;
			shear_y_q  <= '0;
			persp_x_q  <= '0;
			shear_x_q  <= '0;
			scale_y_q  <= COORD_W'(1) << COORD_FRAC;
			persp_y_q  <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SCALE_X:  scale_x_q  <= cfg_wdata;
				REG_SHEAR_Y:  shear_y_q  <= cfg_wdata;
				REG_PERSP_X:  persp_x_q  <= cfg_wdata;
				REG_SHEAR_X:  shear_x_q  <= cfg_wdata;
				REG_SCALE_Y:  scale_y_q  <= cfg_wdata;
				REG_PERSP_Y:  persp_y_q  <= cfg_wdata;
				REG_OFFSET_X: offset_x_q <= cfg_wdata;
				REG_OFFSET_Y: offset_y_q <= cfg_wdata;
				default:      scale_x_q  <= scale_x_q;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Point capture: absolute, or saturated offset from the last point
	// ---------------------------------------------------------------
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign pt_x = mode ? sat_add(last_x_q, coord_x) : coord_x;
	assign pt_y = mode ? sat_add(last_y_q, coord_y) : coord_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (accept) begin
			last_x_q <= pt_x;
			last_y_q <= pt_y;
		end
	end

	// accumulator seeds: the unit term of w and the translations, at 2*frac bits
	assign init_den   = ACC_W'(1) << (2 * COORD_FRAC);
	assign init_num_x = ACC_W'(offset_x_q) <<< COORD_FRAC;
	assign init_num_y = ACC_W'(offset_y_q) <<< COORD_FRAC;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		mac_ctl   = '{init: 1'b0, mul: 1'b0, dst: ACC_DEN};
		op_a      = '0;
		op_b      = '0;
		div_start = 1'b0;
		div_num   = num_x;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mac_ctl.init = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				mac_ctl.mul = 1'b1;
				unique case (step_q)
					T_DEN_X: begin
						op_a = persp_x_q; op_b = last_x_q; mac_ctl.dst = ACC_DEN;
					end
					T_DEN_Y: begin
						op_a = persp_y_q; op_b = last_y_q; mac_ctl.dst = ACC_DEN;
					end
					T_NUM_XX: begin
						op_a = scale_x_q; op_b = last_x_q; mac_ctl.dst = ACC_NUM_X;
					end
					T_NUM_XY: begin
						op_a = shear_x_q; op_b = last_y_q; mac_ctl.dst = ACC_NUM_X;
					end
					T_NUM_YX: begin
						op_a = shear_y_q; op_b = last_x_q; mac_ctl.dst = ACC_NUM_Y;
					end
					T_NUM_YY: begin
						op_a = scale_y_q; op_b = last_y_q; mac_ctl.dst = ACC_NUM_Y;
					end
					default: begin
						op_a = '0; op_b = '0; mac_ctl.dst = ACC_DEN;
					end
				endcase
				if (step_q == T_NUM_YY) state_d = S_DRAIN;
			end
			// last product lands in its accumulator
			S_DRAIN: state_d = S_CHKW;
			S_CHKW: begin
				if (den == '0) begin
					state_d = S_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIVX;
				end
			end
			S_DIVX: begin
				if (div_stat.done) begin
					div_start = 1'b1;
					div_num   = num_y;
					state_d   = S_DIVY;
				end
			end
			S_DIVY: if (div_stat.done) state_d = S_FIN;
			// hold here while the previous result is still unclaimed
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= T_DEN_X;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				step_q <= T_DEN_X;
			end else if (state_q == S_MUL) begin
				step_q <= mac_term_t'(3'(step_q + 3'd1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHKW) zero_q <= (den == '0);
		if (state_q == S_DIVX && div_stat.done) begin
			code_x_q <= div_code;
			oor_x_q  <= div_stat.oor;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_comb begin
		priority if (zero_q)                     res_status = ST_ZERO;
		else if (oor_x_q || div_stat.oor)        res_status = ST_RANGE;
		else                                     res_status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_status;
			dac_x_q  <= (res_status == ST_OK) ? code_x_q : '0;
			dac_y_q  <= (res_status == ST_OK) ? div_code : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign dac_x     = dac_x_q;
	assign dac_y     = dac_y_q;
	assign status    = status_q;

	// ---------------------------------------------------------------
	// Datapath units
	// ---------------------------------------------------------------
	ppd_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl),
		.op_a       (op_a),
		.op_b       (op_b),
		.init_den   (init_den),
		.init_num_x (init_num_x),
		.init_num_y (init_num_y),
		.den        (den),
		.num_x      (num_x),
		.num_y      (num_y)
	);

	ppd_div #(
		.ACC_W    (ACC_W),
		.DAC_BITS (DAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den),
		.code   (div_code),
		.stat   (div_stat)
	);

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("divider busy while the sequencer is idle");

	a_accept_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready still high after accepting a word");

	a_reject_zero_codes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (dac_x == '0 && dac_y == '0))
		else $error("nonzero DAC code on a rejected point");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIVX || state_q == S_DIVY))
		else $error("divider finished outside a divide state");

endmodule

`default_nettype wire

>>> sv/ppd_mac.sv
// Shared multiply-accumulate unit: one registered 16x16 multiplier feeding
// three accumulators (denominator, x numerator, y numerator). Uses ppd_pkg.
`default_nettype none

module ppd_mac import ppd_pkg::*; #(
	parameter int ACC_W = acc_width(COORD_FRAC_DEF)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [COORD_W-1:0] op_a,
	input  wire logic signed [COORD_W-1:0] op_b,
	input  wire logic signed [ACC_W-1:0]   init_den,
	input  wire logic signed [ACC_W-1:0]   init_num_x,
	input  wire logic signed [ACC_W-1:0]   init_num_y,
	output logic signed [ACC_W-1:0]        den,
	output logic signed [ACC_W-1:0]        num_x,
	output logic signed [ACC_W-1:0]        num_y
);

	logic signed [2*COORD_W-1:0] prod_s1;
	acc_sel_t                    dst_s1;
	logic                        vld_s1;
	logic signed [ACC_W-1:0]     prod_ext;
	logic signed [ACC_W-1:0]     den_q;
	logic signed [ACC_W-1:0]     num_x_q;
	logic signed [ACC_W-1:0]     num_y_q;

	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.mul;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= op_a * op_b;
			dst_s1  <= ctl.dst;
		end
	end

	// seed on a new point, then fold in each registered product
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			den_q   <= init_den;
			num_x_q <= init_num_x;
			num_y_q <= init_num_y;
		end else if (vld_s1) begin
			unique case (dst_s1)
				ACC_DEN:   den_q   <= den_q + prod_ext;
				ACC_NUM_X: num_x_q <= num_x_q + prod_ext;
				ACC_NUM_Y: num_y_q <= num_y_q + prod_ext;
				default:   den_q   <= den_q;
			endcase
		end
	end

	assign den   = den_q;
	assign num_x = num_x_q;
	assign num_y = num_y_q;

endmodule

`default_nettype wire

>>> sv/ppd_div.sv
// Serial restoring divider producing one DAC code bit per cycle from
// trunc((num + den) * 2^(DAC_BITS-1) / den), with an out-of-range flag. Uses ppd_pkg.
`default_nettype none

module ppd_div import ppd_pkg::*; #(
	parameter int ACC_W    = acc_width(COORD_FRAC_DEF),
	parameter int DAC_BITS = DAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic signed [ACC_W-1:0] num,
	input  wire logic signed [ACC_W-1:0] den,
	output logic [DAC_BITS-1:0]          code,
	output div_stat_t                    stat
);

	localparam int MAG_W = ACC_W + 1;
	localparam int CNT_W = $clog2(DAC_BITS);

	div_state_t              state_q;
	div_state_t              state_d;
	logic [MAG_W-1:0]        r_q;
	logic [MAG_W-1:0]        b_q;
	logic [DAC_BITS-1:0]     q_q;
	logic                    neg_q;
	logic                    ovf_q;
	logic                    first_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;

	logic signed [MAG_W-1:0] sum;
	logic signed [MAG_W-1:0] den_ext;
	logic [MAG_W-1:0]        a_mag;
	logic [MAG_W-1:0]        b_mag;
	logic                    neg;
	logic [MAG_W-1:0]        trial;
	logic [MAG_W-1:0]        diff;
	logic                    ge;
	logic                    last;

	assign den_ext = MAG_W'(den);
	assign sum     = MAG_W'(num) + den_ext;
	assign a_mag   = sum[MAG_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
	assign b_mag   = den_ext[MAG_W-1] ? MAG_W'(-den_ext) : MAG_W'(den_ext);
	assign neg     = (sum[MAG_W-1] ^ den[ACC_W-1]) && (sum != '0);

	// first step takes the integer bit, later steps shift in fraction bits
	assign trial = first_q ? r_q : {r_q[MAG_W-2:0], 1'b0};
	assign ge    = (trial >= b_q);
	assign diff  = trial - b_q;
	assign last  = (cnt_q == CNT_W'(DAC_BITS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE:  if (start) state_d = DV_CHECK;
			DV_CHECK: state_d = DV_RUN;
			DV_RUN:   if (last) state_d = DV_IDLE;
			default:  state_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
			first_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DV_RUN) && last;
			if (state_q == DV_CHECK) begin
				first_q <= 1'b1;
				cnt_q   <= '0;
			end else if (state_q == DV_RUN) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			r_q   <= a_mag;
			b_q   <= b_mag;
			neg_q <= neg;
		end else if (state_q == DV_CHECK) begin
			// quotient fits in DAC_BITS only if |num + den| < 2 * |den|
			ovf_q <= ({1'b0, r_q} >= {b_q, 1'b0});
		end else if (state_q == DV_RUN) begin
			r_q <= ge ? diff : trial;
			q_q <= {q_q[DAC_BITS-2:0], ge};
		end
	end

	assign code      = q_q;
	assign stat.busy = (state_q != DV_IDLE);
	assign stat.done = done_q;
	assign stat.oor  = ovf_q | (neg_q & (q_q != '0));

endmodule

`default_nettype wire
